/* sv/dnstw_pkg.sv */
// Shared types and constants for the domain name text-to-wire converter.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
`default_nettype none

package dnstw_pkg;

  // Error codes carried on the result word
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_LONG_NAME  = 2'd1;
  localparam logic [1:0] ERR_EMPTY_LBL  = 2'd2;
  localparam logic [1:0] ERR_LONG_LBL   = 2'd3;

  // Most result words that one input word can cause
  localparam int RES_MAX   = 6;
  localparam int RES_IDX_W = $clog2(RES_MAX);
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);

  // Depth of the bundle queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // One wire-format result word
  typedef struct packed {
    logic [7:0] wire_byte;
    logic [7:0] byte_offset;
    logic       name_done;
    logic [1:0] error_code;
  } res_t;

  // All results of one input word, in output order
  typedef struct packed {
    logic [RES_CNT_W-1:0]       cnt;
    res_t [RES_MAX-1:0]         res;
  } bundle_t;

endpackage

`default_nettype wire

/* sv/dnstw_channels.sv */
// Valid/ready channel interfaces for text input words and wire-format result words.
// Depends on nothing.
`default_nettype none

interface dnstw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       char_valid;
  logic       final_req;

  modport source (output valid, character, char_valid, final_req, input ready);
  modport sink   (input valid, character, char_valid, final_req, output ready);
endinterface

interface dnstw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic [7:0] byte_offset;
  logic       name_done;
  logic [1:0] error_code;

  modport source (output valid, wire_byte, byte_offset, name_done, error_code, input ready);
  modport sink   (input valid, wire_byte, byte_offset, name_done, error_code, output ready);
endinterface

`default_nettype wire

/* sv/dnstw_front.sv */
// Front end: accepts text words, tracks label/escape state and builds the
// bundle of result words for each one. Depends on dnstw_pkg and dnstw_in_if.
`default_nettype none

module dnstw_front #(
  parameter int MAX_NAME_LEN  = 255,
  parameter int MAX_LABEL_LEN = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dnstw_in_if.sink               in_ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output dnstw_pkg::bundle_t     q_data
);

  localparam logic [8:0] MaxName  = 9'(MAX_NAME_LEN);
  localparam logic [8:0] MaxLabel = 9'(MAX_LABEL_LEN);

  // Escape tracking codes
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_BSL  = 2'd1;
  localparam logic [1:0] ESC_ONE  = 2'd2;
  localparam logic [1:0] ESC_TWO  = 2'd3;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Working copy of the position state plus the results gathered so far
  typedef struct packed {
    logic [8:0]                                 wp;
    logic [7:0]                                 hdr;
    logic                                       ended;
    logic [dnstw_pkg::RES_CNT_W-1:0]            n;
    dnstw_pkg::res_t [dnstw_pkg::RES_MAX-1:0]   res;
  } acc_t;

  function automatic acc_t f_emit(acc_t a, logic [7:0] b, logic [7:0] off,
                                  logic done, logic [1:0] err);
    acc_t r;
    r = a;
    if (r.n < dnstw_pkg::RES_CNT_W'(dnstw_pkg::RES_MAX)) begin
      r.res[r.n[dnstw_pkg::RES_IDX_W-1:0]] = '{wire_byte: b, byte_offset: off,
                                               name_done: done, error_code: err};
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t f_fail(acc_t a, logic [1:0] code);
    acc_t r;
    r = f_emit(a, 8'd0, 8'd0, 1'b1, code);
    r.ended = 1'b1;
    return r;
  endfunction

  // Content byte at the write position, or name-too-long
  function automatic acc_t f_put(acc_t a, logic [7:0] b);
    acc_t r;
    r = a;
    if (!r.ended) begin
      if (r.wp >= MaxName) begin
        r = f_fail(r, dnstw_pkg::ERR_LONG_NAME);
      end else begin
        r = f_emit(r, b, r.wp[7:0], 1'b0, dnstw_pkg::ERR_OK);
        r.wp = r.wp + 9'd1;
      end
    end
    return r;
  endfunction

  // Incomplete escape: one zero byte, then the digits seen as text
  function automatic acc_t f_flush(acc_t a, logic [1:0] ph, logic [3:0] dhi,
                                   logic [3:0] dlo);
    acc_t r;
    r = a;
    if (ph != ESC_NONE) begin
      r = f_put(r, 8'd0);
      if (ph == ESC_ONE) begin
        r = f_put(r, CH_ZERO + {4'd0, dhi});
      end else if (ph == ESC_TWO) begin
        r = f_put(r, CH_ZERO + {4'd0, dhi});
        r = f_put(r, CH_ZERO + {4'd0, dlo});
      end
    end
    return r;
  endfunction

  // Dot: close the open label, or the lone root name
  function automatic acc_t f_dot(acc_t a, logic last);
    acc_t       r;
    logic [8:0] len;
    r   = a;
    len = r.wp - {1'b0, r.hdr} - 9'd1;
    if (!r.ended) begin
      if (r.wp >= MaxName) begin
        r = f_fail(r, dnstw_pkg::ERR_LONG_NAME);
      end else if (r.wp == {1'b0, r.hdr} + 9'd1) begin
        if (r.wp == 9'd1 && last) begin
          r = f_emit(r, 8'd0, 8'd0, 1'b1, dnstw_pkg::ERR_OK);
          r.ended = 1'b1;
        end else begin
          r = f_fail(r, dnstw_pkg::ERR_EMPTY_LBL);
        end
      end else if (len > MaxLabel) begin
        r = f_fail(r, dnstw_pkg::ERR_LONG_LBL);
      end else begin
        r = f_emit(r, len[7:0], r.hdr, 1'b0, dnstw_pkg::ERR_OK);
        r.hdr = r.wp[7:0];
        r.wp  = r.wp + 9'd1;
      end
    end
    return r;
  endfunction

  // End of text: close a non-empty label, then the root byte
  function automatic acc_t f_finish(acc_t a);
    acc_t       r;
    logic [8:0] len;
    r   = a;
    len = r.wp - {1'b0, r.hdr} - 9'd1;
    if (!r.ended) begin
      if (r.wp != {1'b0, r.hdr} + 9'd1) begin
        if (len > MaxLabel) begin
          r = f_fail(r, dnstw_pkg::ERR_LONG_LBL);
        end else if (r.wp >= MaxName) begin
          r = f_fail(r, dnstw_pkg::ERR_LONG_NAME);
        end else begin
          r = f_emit(r, len[7:0], r.hdr, 1'b0, dnstw_pkg::ERR_OK);
          r.hdr = r.wp[7:0];
        end
      end
      if (!r.ended) begin
        r = f_emit(r, 8'd0, r.hdr, 1'b1, dnstw_pkg::ERR_OK);
        r.ended = 1'b1;
      end
    end
    return r;
  endfunction

  // Name state
  logic [7:0] hdr_r,  hdr_nxt;
  logic [8:0] wpos_r, wpos_nxt;
  logic [1:0] esc_r,  esc_nxt;
  logic [3:0] dhi_r,  dhi_nxt;
  logic [3:0] dlo_r,  dlo_nxt;
  logic       disc_r, disc_nxt;

  acc_t       acc;
  logic [1:0] esc;
  logic [3:0] dhi, dlo;
  logic       do_plain;
  logic       is_dig;
  logic [3:0] dval;
  logic [9:0] esc_val;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_dig  = (in_ch.character >= CH_ZERO) && (in_ch.character <= CH_NINE);
  assign dval    = 4'(in_ch.character - CH_ZERO);
  assign esc_val = 10'(dhi_r) * 10'd100 + 10'(dlo_r) * 10'd10 + 10'(dval);

  // Per-word evaluation: escape step, plain character, end of text
  always_comb begin
    acc       = '0;
    acc.wp    = wpos_r;
    acc.hdr   = hdr_r;
    esc       = esc_r;
    dhi       = dhi_r;
    dlo       = dlo_r;
    do_plain  = 1'b0;

    if (!disc_r && in_ch.char_valid) begin
      unique case (esc_r)
        ESC_NONE: begin
          do_plain = 1'b1;
        end
        ESC_BSL: begin
          if (is_dig) begin
            esc = ESC_ONE;
            dhi = dval;
          end else begin
            esc = ESC_NONE;
            acc = f_put(acc, in_ch.character);
          end
        end
        ESC_ONE: begin
          if (is_dig) begin
            esc = ESC_TWO;
            dlo = dval;
          end else begin
            acc      = f_flush(acc, esc_r, dhi_r, dlo_r);
            esc      = ESC_NONE;
            do_plain = !acc.ended;
          end
        end
        ESC_TWO: begin
          if (is_dig) begin
            esc = ESC_NONE;
            acc = f_put(acc, (esc_val > 10'd255) ? 8'd0 : esc_val[7:0]);
          end else begin
            acc      = f_flush(acc, esc_r, dhi_r, dlo_r);
            esc      = ESC_NONE;
            do_plain = !acc.ended;
          end
        end
        default: begin
          esc = ESC_NONE;
        end
      endcase
    end

    // Plain character handling
    if (do_plain) begin
      if (in_ch.character == CH_DOT) begin
        acc = f_dot(acc, in_ch.final_req);
      end else if (in_ch.character == CH_BSL) begin
        if (acc.wp >= MaxName) begin
          acc = f_fail(acc, dnstw_pkg::ERR_LONG_NAME);
        end else begin
          esc = ESC_BSL;
        end
      end else begin
        acc = f_put(acc, in_ch.character);
      end
    end

    // End of text
    if (!disc_r && !acc.ended && in_ch.final_req) begin
      acc = f_flush(acc, esc, dhi, dlo);
      esc = ESC_NONE;
      acc = f_finish(acc);
    end
  end

  // Next state
  always_comb begin
    hdr_nxt  = acc.hdr;
    wpos_nxt = acc.wp;
    esc_nxt  = esc;
    dhi_nxt  = dhi;
    dlo_nxt  = dlo;
    disc_nxt = 1'b0;
    if (disc_r) begin
      hdr_nxt  = hdr_r;
      wpos_nxt = wpos_r;
      esc_nxt  = esc_r;
      dhi_nxt  = dhi_r;
      dlo_nxt  = dlo_r;
      disc_nxt = !in_ch.final_req;
    end
    if (disc_r ? in_ch.final_req : (acc.ended || in_ch.final_req)) begin
      hdr_nxt  = 8'd0;
      wpos_nxt = 9'd1;
      esc_nxt  = ESC_NONE;
      dhi_nxt  = 4'd0;
      dlo_nxt  = 4'd0;
    end
    if (!disc_r) begin
      disc_nxt = acc.ended && !in_ch.final_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 8'd0;
      wpos_r <= 9'd1;
      esc_r  <= ESC_NONE;
      dhi_r  <= 4'd0;
      dlo_r  <= 4'd0;
      disc_r <= 1'b0;
    end else if (accept) begin
      hdr_r  <= hdr_nxt;
      wpos_r <= wpos_nxt;
      esc_r  <= esc_nxt;
      dhi_r  <= dhi_nxt;
      dlo_r  <= dlo_nxt;
      disc_r <= disc_nxt;
    end
  end

  // Only words that produce results enter the queue
  assign q_push     = accept && (acc.n != '0);
  assign q_data.cnt = acc.n;
  assign q_data.res = acc.res;

endmodule

`default_nettype wire

/* sv/dnstw_queue.sv */
// Short FIFO of result bundles between the front and back ends.
// Depends on dnstw_pkg.
`default_nettype none

module dnstw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire dnstw_pkg::bundle_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output dnstw_pkg::bundle_t      head
);

  dnstw_pkg::bundle_t                 mem_r [dnstw_pkg::QDEPTH];
  logic [dnstw_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [dnstw_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [dnstw_pkg::QCNT_W-1:0]       cnt_r;
  logic                               do_push;
  logic                               do_pop;

  assign full    = (cnt_r == dnstw_pkg::QCNT_W'(dnstw_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == dnstw_pkg::QPTR_W'(dnstw_pkg::QDEPTH - 1)) ? '0
                                                                  : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == dnstw_pkg::QPTR_W'(dnstw_pkg::QDEPTH - 1)) ? '0
                                                                  : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dnstw_back.sv */
// Back end: walks the head bundle one result word per handshake and pops it
// after the last one. Depends on dnstw_pkg and dnstw_out_if.
`default_nettype none

module dnstw_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire dnstw_pkg::bundle_t q_head,
  output logic                    q_pop,
  dnstw_out_if.source             out_ch
);

  logic [dnstw_pkg::RES_IDX_W-1:0] idx_r;
  logic                            last_res;
  logic                            take;
  dnstw_pkg::res_t                 cur;

  assign cur      = q_head.res[idx_r];
  assign last_res = (dnstw_pkg::RES_CNT_W'(idx_r) == q_head.cnt - 1'b1);
  assign take     = out_ch.valid && out_ch.ready;
  assign q_pop    = take && last_res;

  // Result word drive
  assign out_ch.valid       = !q_empty;
  assign out_ch.wire_byte   = cur.wire_byte;
  assign out_ch.byte_offset = cur.byte_offset;
  assign out_ch.name_done   = cur.name_done;
  assign out_ch.error_code  = cur.error_code;

  // Position within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= last_res ? '0 : idx_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/dns_name_text_to_wire.sv */
// Top level of the domain name text-to-wire converter: front, bundle queue, back.
// Depends on dnstw_pkg, dnstw_channels, dnstw_front, dnstw_queue, dnstw_back.
//
//   channel  dir  payload                                        handshake
//   in_ch    in   character[8] char_valid[1] final_req[1]        valid/ready
//   out_ch   out  wire_byte[8] byte_offset[8] name_done[1]       valid/ready
//                 error_code[2]
//
// Accepts one text word per cycle while the queue is not full; its state update completes in that cycle.
// A word causing k result words (0..6) holds the back end for k output handshakes; the
// two-bundle queue absorbs bursts and in_ch.ready drops only when it is full.
// Words causing no result (escape digits, discarded words) never enter the queue.
// Reset is synchronous (rst_n low); no clearing pass, ready right after reset.
`default_nettype none

module dns_name_text_to_wire #(
  parameter int MAX_NAME_LEN  = 255,
  parameter int MAX_LABEL_LEN = 63
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dnstw_in_if.sink    in_ch,
  dnstw_out_if.source out_ch
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  dnstw_pkg::bundle_t q_data;
  dnstw_pkg::bundle_t q_head;

  dnstw_front #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  dnstw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  dnstw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A pushed bundle always holds between one and six words
  a_bundle_count : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_data.cnt != '0) &&
               (q_data.cnt <= dnstw_pkg::RES_CNT_W'(dnstw_pkg::RES_MAX)))
    else $error("bundle count out of range");

  // The name-ending word is always the last of its bundle
  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.name_done) |-> q_pop)
    else $error("name_done word not last in bundle");

  // Error words end the name and carry zero byte and offset
  a_err_shape : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error_code != dnstw_pkg::ERR_OK) |->
      (out_ch.name_done && out_ch.wire_byte == 8'd0 && out_ch.byte_offset == 8'd0))
    else $error("malformed error word");

  // Words are only taken while the queue has room
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ch.ready)
    else $error("input taken while queue full");

endmodule

`default_nettype wire
